// ===== sv/sstok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstok_pkg: shared types and constants of the script source tokenizer
// Token kinds, lexer states, character classes and the keyword table.
// ----------------------------------------------------------------------------
package sstok_pkg;

  // Token kinds
  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_PROG   = 6'd1;
  localparam logic [5:0] K_VALUE  = 6'd2;
  localparam logic [5:0] K_OR3    = 6'd3;
  localparam logic [5:0] K_AND3   = 6'd4;
  localparam logic [5:0] K_SUB3   = 6'd5;
  localparam logic [5:0] K_COMB3  = 6'd6;
  localparam logic [5:0] K_XLATE  = 6'd7;
  localparam logic [5:0] K_SCALE  = 6'd8;
  localparam logic [5:0] K_OR2    = 6'd9;
  localparam logic [5:0] K_AND2   = 6'd10;
  localparam logic [5:0] K_EQ     = 6'd11;
  localparam logic [5:0] K_NE     = 6'd12;
  localparam logic [5:0] K_LE     = 6'd13;
  localparam logic [5:0] K_GE     = 6'd14;
  localparam logic [5:0] K_MIRROR = 6'd15;
  localparam logic [5:0] K_LPAREN = 6'd16;
  localparam logic [5:0] K_RPAREN = 6'd17;
  localparam logic [5:0] K_LBRACE = 6'd18;
  localparam logic [5:0] K_RBRACE = 6'd19;
  localparam logic [5:0] K_LBRACK = 6'd20;
  localparam logic [5:0] K_RBRACK = 6'd21;
  localparam logic [5:0] K_COMMA  = 6'd22;
  localparam logic [5:0] K_SEMI   = 6'd23;
  localparam logic [5:0] K_COLON  = 6'd24;
  localparam logic [5:0] K_DOT    = 6'd25;
  localparam logic [5:0] K_ASSIGN = 6'd26;
  localparam logic [5:0] K_LT     = 6'd27;
  localparam logic [5:0] K_GT     = 6'd28;
  localparam logic [5:0] K_PLUS   = 6'd29;
  localparam logic [5:0] K_MINUS  = 6'd30;
  localparam logic [5:0] K_STAR   = 6'd31;
  localparam logic [5:0] K_SLASH  = 6'd32;
  localparam logic [5:0] K_BSLASH = 6'd33;
  localparam logic [5:0] K_AT     = 6'd34;
  localparam logic [5:0] K_BANG   = 6'd35;
  localparam logic [5:0] K_STRING = 6'd36;
  localparam logic [5:0] K_INT    = 6'd37;
  localparam logic [5:0] K_FLOAT  = 6'd38;
  localparam logic [5:0] K_KW0    = 6'd39;
  localparam logic [5:0] K_IDENT  = 6'd50;
  localparam logic [5:0] K_ERROR  = 6'd51;

  localparam logic [62:0] INT_MAX = {63{1'b1}};
  localparam int          NUM_KW  = 11;

  // Keyword text packed big-endian into a 64-bit window, and lengths
  localparam logic [63:0] KW_WIN [NUM_KW] = '{
    64'h766172, 64'h6966, 64'h656c7365, 64'h7768696c65, 64'h666f72,
    64'h72657475726e, 64'h627265616b, 64'h636f6e74696e7565, 64'h65786974,
    64'h6173796e63, 64'h73796e63
  };
  localparam logic [15:0] KW_LEN [NUM_KW] = '{
    16'd3, 16'd2, 16'd4, 16'd5, 16'd3, 16'd6, 16'd5, 16'd8, 16'd4, 16'd5, 16'd4
  };

  // Lexer states, one-hot
  typedef enum logic [30:0] {
    S_START   = 31'h00000001,
    S_LINECMT = 31'h00000002,
    S_SLASH   = 31'h00000004,
    S_HASH    = 31'h00000008,
    S_BAR1    = 31'h00000010,
    S_BAR2    = 31'h00000020,
    S_AMP1    = 31'h00000040,
    S_AMP2    = 31'h00000080,
    S_MIN1    = 31'h00000100,
    S_MIN2    = 31'h00000200,
    S_PLUS1   = 31'h00000400,
    S_PLUS2   = 31'h00000800,
    S_GT1     = 31'h00001000,
    S_GT2     = 31'h00002000,
    S_STAR1   = 31'h00004000,
    S_STAR2   = 31'h00008000,
    S_EQ1     = 31'h00010000,
    S_BANG1   = 31'h00020000,
    S_LT1     = 31'h00040000,
    S_STR     = 31'h00080000,
    S_ESC     = 31'h00100000,
    S_INT     = 31'h00200000,
    S_FRAC    = 31'h00400000,
    S_IE      = 31'h00800000,
    S_IES     = 31'h01000000,
    S_FE      = 31'h02000000,
    S_FES     = 31'h04000000,
    S_EXP     = 31'h08000000,
    S_IDENT   = 31'h10000000,
    S_HALT    = 31'h20000000,
    S_FRESH   = 31'h40000000
  } lex_state_t;

  // Character class
  typedef struct packed {
    logic digit;
    logic alpha;
    logic blank;
  } cls_t;

  // Source word as handed from front to lexer
  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    cls_t       cls;
  } item_t;

  // Result word
  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [31:0] line_number;
    logic [62:0] integer_value;
    logic [7:0]  bad_char;
    logic        last_of_run;
  } tok_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r.digit = (c >= 8'h30) && (c <= 8'h39);
    r.alpha = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
              || (c == 8'h5f);
    r.blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0d);
    return r;
  endfunction

  // Keyword or identifier, from the first eight bytes and the length
  function automatic logic [5:0] kw_kind(input logic [63:0] win, input logic [15:0] len);
    logic [5:0] k;
    k = K_IDENT;
    if (len <= 16'd8) begin
      for (int i = NUM_KW - 1; i >= 0; i--) begin
        if (win == KW_WIN[i] && len == KW_LEN[i]) k = 6'(int'(K_KW0) + i);
      end
    end
    return k;
  endfunction

endpackage

// ===== sv/sstok_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstok_in_if / sstok_out_if: valid-ready channels of the tokenizer
// Source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface sstok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_source;

  modport source (output valid, char_byte, end_of_source, input ready);
  modport sink   (input valid, char_byte, end_of_source, output ready);
endinterface

interface sstok_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [31:0] start_offset;
  logic [15:0] token_length;
  logic [31:0] line_number;
  logic [62:0] integer_value;
  logic [7:0]  bad_char;
  logic        last_of_run;

  modport source (output valid, token_kind, start_offset, token_length, line_number,
                  integer_value, bad_char, last_of_run, input ready);
  modport sink   (input valid, token_kind, start_offset, token_length, line_number,
                  integer_value, bad_char, last_of_run, output ready);
endinterface

// ===== sv/sstok_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstok_front: input stage of the tokenizer
// Accepts source words, tags each byte with its offset and class, and
// queues them for the lexer in a two-entry queue.
// ----------------------------------------------------------------------------
module sstok_front #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  sstok_in_if.sink               chars,
  output logic                   item_valid,
  output sstok_pkg::item_t       item,
  output logic [OFFSET_BITS-1:0] item_off,
  input  logic                   item_pop
);

  localparam int DEPTH = 2;

  sstok_pkg::item_t       mem   [DEPTH];
  logic [OFFSET_BITS-1:0] offm  [DEPTH];
  logic [1:0]             cnt;
  logic                   wp;
  logic                   rp;
  logic [OFFSET_BITS-1:0] byte_cnt;
  logic                   accept;

  assign chars.ready = (cnt != 2'(DEPTH));
  assign accept      = chars.valid && chars.ready;
  assign item_valid  = (cnt != 2'd0);
  assign item        = mem[rp];
  assign item_off    = offm[rp];

  // pointers, fill count and running byte offset
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= 2'd0;
      wp       <= 1'b0;
      rp       <= 1'b0;
      byte_cnt <= '0;
    end else begin
      if (accept) begin
        wp <= ~wp;
        // end of source restarts offsets for the next source
        if (chars.end_of_source) byte_cnt <= '0;
        else                     byte_cnt <= byte_cnt + OFFSET_BITS'(1);
      end
      if (item_pop) rp <= ~rp;
      unique case ({accept, item_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wp].ch  <= chars.char_byte;
      mem[wp].eos <= chars.end_of_source;
      mem[wp].cls <= sstok_pkg::classify(chars.char_byte);
      offm[wp]    <= byte_cnt;
    end
  end

endmodule

// ===== sv/sstok_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstok_lexer: token state machine of the tokenizer
// Steps one byte a cycle while the result queue is not full, from its
// re-scan buffer first, then from the front queue. Holds the newest token
// until it knows whether it closes the run of its source word.
// ----------------------------------------------------------------------------
module sstok_lexer #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   source_mode,
  input  logic                   item_valid,
  input  sstok_pkg::item_t       item,
  input  logic [OFFSET_BITS-1:0] item_off,
  output logic                   item_pop,
  input  logic                   out_full,
  output logic                   out_wr,
  output sstok_pkg::tok_t        out_tok
);

  typedef struct packed {
    logic [7:0]             ch;
    logic                   eos;
    logic [OFFSET_BITS-1:0] off;
  } pbe_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] k);
    logic [16:0] s;
    s = {1'b0, a} + 17'(k);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  sstok_pkg::lex_state_t state, state_next;
  logic [LINE_BITS-1:0]   line_cnt, line_next;
  logic [OFFSET_BITS-1:0] tok_off, tstart_next;
  logic [LINE_BITS-1:0]   tok_line, tline_next;
  logic [62:0]            acc, acc_next;
  logic [63:0]            kwin, kwin_next;
  logic [15:0]            ilen, ilen_next;
  logic [7:0]             pend1, pend1_next, pend2, pend2_next;

  pbe_t       pb [4];
  pbe_t       rest [4];
  pbe_t       pbn [4];
  pbe_t       psh [3];
  logic [2:0] pb_cnt, rest_cnt, new_cnt;
  logic [1:0] push_n;

  sstok_pkg::tok_t hold_tok;
  logic            hold_vld;
  logic            hold_done;

  // selected byte for this step
  logic                   from_pb, go, fresh_step, step_char, done_now, tok_new;
  logic [7:0]             c;
  logic                   e;
  logic [OFFSET_BITS-1:0] off, off_m1, off_m2;
  sstok_pkg::cls_t        cls;
  pbe_t                   cur;

  // emission
  logic                   em;
  logic [5:0]             em_kind;
  logic [OFFSET_BITS-1:0] em_start;
  logic [47:0]            em_start_w;
  logic [15:0]            em_len;
  logic [LINE_BITS-1:0]   em_line;
  logic [62:0]            em_ival;
  logic [7:0]             em_bad;
  sstok_pkg::tok_t        new_tok;

  logic [15:0] g1, g2, g3;
  logic [66:0] acc_mul;
  logic [62:0] acc_sat;
  logic [LINE_BITS-1:0] line_inc;

  assign from_pb    = (pb_cnt != 3'd0);
  assign go         = !out_full && (from_pb || item_valid);
  assign fresh_step = (state == sstok_pkg::S_FRESH);
  assign step_char  = go && !fresh_step;
  assign item_pop   = step_char && !from_pb;

  assign c      = from_pb ? pb[0].ch  : item.ch;
  assign e      = from_pb ? pb[0].eos : item.eos;
  assign off    = from_pb ? pb[0].off : item_off;
  assign cls    = from_pb ? sstok_pkg::classify(pb[0].ch) : item.cls;
  assign off_m1 = off - OFFSET_BITS'(1);
  assign off_m2 = off - OFFSET_BITS'(2);
  assign cur    = '{ch: c, eos: e, off: off};

  assign g1 = sat_add(ilen, 2'd1);
  assign g2 = sat_add(ilen, 2'd2);
  assign g3 = sat_add(ilen, 2'd3);

  // decimal accumulate, saturating
  assign acc_mul  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 67'(c[3:0]);
  assign acc_sat  = (acc_mul > 67'(sstok_pkg::INT_MAX)) ? sstok_pkg::INT_MAX
                                                         : acc_mul[62:0];
  assign line_inc = (&line_cnt) ? line_cnt : line_cnt + LINE_BITS'(1);

  // next state of one step
  always_comb begin
    state_next  = state;
    line_next   = line_cnt;
    tstart_next = tok_off;
    tline_next  = tok_line;
    acc_next    = acc;
    kwin_next   = kwin;
    ilen_next   = ilen;
    pend1_next  = pend1;
    pend2_next  = pend2;
    em          = 1'b0;
    em_kind     = sstok_pkg::K_EOF;
    em_start    = tok_off;
    em_len      = ilen;
    em_line     = tok_line;
    em_ival     = '0;
    em_bad      = '0;
    push_n      = 2'd0;
    psh[0]      = cur;
    psh[1]      = cur;
    psh[2]      = cur;

    if (fresh_step) begin
      // mode sentinel ahead of the first byte of a source
      em       = 1'b1;
      em_kind  = source_mode ? sstok_pkg::K_VALUE : sstok_pkg::K_PROG;
      em_start = '0;
      em_len   = 16'd0;
      em_line  = line_cnt;
      state_next = sstok_pkg::S_START;
    end else if (state == sstok_pkg::S_START || (state == sstok_pkg::S_HALT && e)) begin
      if (e) begin
        // end of source: EOF, then back to reset values
        em          = 1'b1;
        em_kind     = sstok_pkg::K_EOF;
        em_start    = off;
        em_len      = 16'd0;
        em_line     = line_cnt;
        state_next  = sstok_pkg::S_FRESH;
        line_next   = LINE_BITS'(1);
        tstart_next = '0;
        tline_next  = LINE_BITS'(1);
        acc_next    = '0;
        kwin_next   = '0;
        ilen_next   = '0;
      end else if (cls.blank) begin
        state_next = sstok_pkg::S_START;
      end else if (c == 8'h0a) begin
        line_next = line_inc;
      end else begin
        tstart_next = off;
        tline_next  = line_cnt;
        ilen_next   = 16'd1;
        state_next  = sstok_pkg::S_START;
        em_start    = off;
        em_len      = 16'd1;
        em_line     = line_cnt;
        unique case (c)
          "/":  state_next = sstok_pkg::S_SLASH;
          "#":  state_next = sstok_pkg::S_HASH;
          "|":  state_next = sstok_pkg::S_BAR1;
          "&":  state_next = sstok_pkg::S_AMP1;
          "-":  state_next = sstok_pkg::S_MIN1;
          "+":  state_next = sstok_pkg::S_PLUS1;
          ">":  state_next = sstok_pkg::S_GT1;
          "*":  state_next = sstok_pkg::S_STAR1;
          "=":  state_next = sstok_pkg::S_EQ1;
          "!":  state_next = sstok_pkg::S_BANG1;
          "<":  state_next = sstok_pkg::S_LT1;
          "\"": state_next = sstok_pkg::S_STR;
          "(":  begin em = 1'b1; em_kind = sstok_pkg::K_LPAREN; end
          ")":  begin em = 1'b1; em_kind = sstok_pkg::K_RPAREN; end
          "{":  begin em = 1'b1; em_kind = sstok_pkg::K_LBRACE; end
          "}":  begin em = 1'b1; em_kind = sstok_pkg::K_RBRACE; end
          "[":  begin em = 1'b1; em_kind = sstok_pkg::K_LBRACK; end
          "]":  begin em = 1'b1; em_kind = sstok_pkg::K_RBRACK; end
          ",":  begin em = 1'b1; em_kind = sstok_pkg::K_COMMA; end
          ";":  begin em = 1'b1; em_kind = sstok_pkg::K_SEMI; end
          ":":  begin em = 1'b1; em_kind = sstok_pkg::K_COLON; end
          ".":  begin em = 1'b1; em_kind = sstok_pkg::K_DOT; end
          "\\": begin em = 1'b1; em_kind = sstok_pkg::K_BSLASH; end
          "@":  begin em = 1'b1; em_kind = sstok_pkg::K_AT; end
          default: begin
            if (cls.digit) begin
              state_next = sstok_pkg::S_INT;
              acc_next   = 63'(c[3:0]);
            end else if (cls.alpha) begin
              state_next = sstok_pkg::S_IDENT;
              kwin_next  = 64'(c);
            end else begin
              // invalid character
              em         = 1'b1;
              em_kind    = sstok_pkg::K_ERROR;
              em_bad     = c;
              state_next = sstok_pkg::S_HALT;
            end
          end
        endcase
      end
    end else begin
      unique case (state)
        sstok_pkg::S_LINECMT: begin
          if (e || c == 8'h0a) begin
            state_next = sstok_pkg::S_START;
            push_n     = 2'd1;
          end
        end
        sstok_pkg::S_SLASH: begin
          if (!e && c == "/") state_next = sstok_pkg::S_LINECMT;
          else begin
            em = 1'b1; em_kind = sstok_pkg::K_SLASH;
            state_next = sstok_pkg::S_START; push_n = 2'd1;
          end
        end
        sstok_pkg::S_HASH: begin
          if (!e && c == "!") state_next = sstok_pkg::S_LINECMT;
          else begin
            em = 1'b1; em_kind = sstok_pkg::K_ERROR; em_len = 16'd1; em_bad = "#";
            state_next = sstok_pkg::S_HALT; push_n = 2'd1;
          end
        end
        sstok_pkg::S_BAR1: begin
          if (!e && c == "|") begin
            ilen_next = g1; state_next = sstok_pkg::S_BAR2;
          end else begin
            em = 1'b1; em_kind = sstok_pkg::K_ERROR; em_len = 16'd1; em_bad = "|";
            state_next = sstok_pkg::S_HALT; push_n = 2'd1;
          end
        end
        sstok_pkg::S_AMP1: begin
          if (!e && c == "&") begin
            ilen_next = g1; state_next = sstok_pkg::S_AMP2;
          end else begin
            em = 1'b1; em_kind = sstok_pkg::K_ERROR; em_len = 16'd1; em_bad = "&";
            state_next = sstok_pkg::S_HALT; push_n = 2'd1;
          end
        end
        sstok_pkg::S_BAR2: begin
          em = 1'b1; state_next = sstok_pkg::S_START;
          if (!e && c == "|") begin
            em_kind = sstok_pkg::K_OR3; em_len = g1; ilen_next = g1;
          end else begin
            em_kind = sstok_pkg::K_OR2; push_n = 2'd1;
          end
        end
        sstok_pkg::S_AMP2: begin
          em = 1'b1; state_next = sstok_pkg::S_START;
          if (!e && c == "&") begin
            em_kind = sstok_pkg::K_AND3; em_len = g1; ilen_next = g1;
          end else begin
            em_kind = sstok_pkg::K_AND2; push_n = 2'd1;
          end
        end
        sstok_pkg::S_MIN1: begin
          if (!e && c == "-") begin
            ilen_next = g1; state_next = sstok_pkg::S_MIN2;
          end else begin
            em = 1'b1; em_kind = sstok_pkg::K_MINUS;
            state_next = sstok_pkg::S_START; push_n = 2'd1;
          end
        end
        sstok_pkg::S_PLUS1: begin
          if (!e && c == "+") begin
            ilen_next = g1; state_next = sstok_pkg::S_PLUS2;
          end else begin
            em = 1'b1; em_kind = sstok_pkg::K_PLUS;
            state_next = sstok_pkg::S_START; push_n = 2'd1;
          end
        end
        sstok_pkg::S_STAR1: begin
          if (!e && c == "*") begin
            ilen_next = g1; state_next = sstok_pkg::S_STAR2;
          end else begin
            em = 1'b1; em_kind = sstok_pkg::K_STAR;
            state_next = sstok_pkg::S_START; push_n = 2'd1;
          end
        end
        // doubled operator: third byte makes the triple, else split the pair
        sstok_pkg::S_MIN2: begin
          em = 1'b1; state_next = sstok_pkg::S_START;
          if (!e && c == "-") begin
            em_kind = sstok_pkg::K_SUB3; em_len = g1; ilen_next = g1;
          end else begin
            em_kind = sstok_pkg::K_MINUS; em_len = 16'd1; ilen_next = 16'd1;
            push_n = 2'd2; psh[0] = '{ch: "-", eos: 1'b0, off: off_m1}; psh[1] = cur;
          end
        end
        sstok_pkg::S_PLUS2: begin
          em = 1'b1; state_next = sstok_pkg::S_START;
          if (!e && c == "+") begin
            em_kind = sstok_pkg::K_COMB3; em_len = g1; ilen_next = g1;
          end else begin
            em_kind = sstok_pkg::K_PLUS; em_len = 16'd1; ilen_next = 16'd1;
            push_n = 2'd2; psh[0] = '{ch: "+", eos: 1'b0, off: off_m1}; psh[1] = cur;
          end
        end
        sstok_pkg::S_STAR2: begin
          em = 1'b1; state_next = sstok_pkg::S_START;
          if (!e && c == "*") begin
            em_kind = sstok_pkg::K_SCALE; em_len = g1; ilen_next = g1;
          end else begin
            em_kind = sstok_pkg::K_STAR; em_len = 16'd1; ilen_next = 16'd1;
            push_n = 2'd2; psh[0] = '{ch: "*", eos: 1'b0, off: off_m1}; psh[1] = cur;
          end
        end
        sstok_pkg::S_GT1: begin
          if (!e && c == ">") begin
            ilen_next = g1; state_next = sstok_pkg::S_GT2;
          end else if (!e && c == "=") begin
            em = 1'b1; em_kind = sstok_pkg::K_GE; em_len = g1; ilen_next = g1;
            state_next = sstok_pkg::S_START;
          end else begin
            em = 1'b1; em_kind = sstok_pkg::K_GT;
            state_next = sstok_pkg::S_START; push_n = 2'd1;
          end
        end
        sstok_pkg::S_GT2: begin
          em = 1'b1; state_next = sstok_pkg::S_START;
          if (!e && c == ">") begin
            em_kind = sstok_pkg::K_XLATE; em_len = g1; ilen_next = g1;
          end else begin
            em_kind = sstok_pkg::K_GT; em_len = 16'd1; ilen_next = 16'd1;
            push_n = 2'd2; psh[0] = '{ch: ">", eos: 1'b0, off: off_m1}; psh[1] = cur;
          end
        end
        sstok_pkg::S_EQ1: begin
          em = 1'b1; state_next = sstok_pkg::S_START;
          if (!e && c == "=") begin
            em_kind = sstok_pkg::K_EQ; em_len = g1; ilen_next = g1;
          end else begin
            em_kind = sstok_pkg::K_ASSIGN; push_n = 2'd1;
          end
        end
        sstok_pkg::S_BANG1: begin
          em = 1'b1; state_next = sstok_pkg::S_START;
          if (!e && c == "=") begin
            em_kind = sstok_pkg::K_NE; em_len = g1; ilen_next = g1;
          end else begin
            em_kind = sstok_pkg::K_BANG; push_n = 2'd1;
          end
        end
        sstok_pkg::S_LT1: begin
          em = 1'b1; state_next = sstok_pkg::S_START;
          if (!e && c == "=") begin
            em_kind = sstok_pkg::K_LE; em_len = g1; ilen_next = g1;
          end else if (!e && c == ">") begin
            em_kind = sstok_pkg::K_MIRROR; em_len = g1; ilen_next = g1;
          end else begin
            em_kind = sstok_pkg::K_LT; push_n = 2'd1;
          end
        end
        // strings; an unterminated one closes at end of source
        sstok_pkg::S_STR: begin
          if (e) begin
            em = 1'b1; em_kind = sstok_pkg::K_STRING;
            state_next = sstok_pkg::S_START; push_n = 2'd1;
          end else begin
            ilen_next = g1;
            if (c == "\"") begin
              em = 1'b1; em_kind = sstok_pkg::K_STRING; em_len = g1;
              state_next = sstok_pkg::S_START;
            end else if (c == "\\") begin
              state_next = sstok_pkg::S_ESC;
            end
          end
        end
        sstok_pkg::S_ESC: begin
          if (e) begin
            em = 1'b1; em_kind = sstok_pkg::K_STRING;
            state_next = sstok_pkg::S_START; push_n = 2'd1;
          end else begin
            ilen_next = g1; state_next = sstok_pkg::S_STR;
          end
        end
        // numbers
        sstok_pkg::S_INT: begin
          if (!e && cls.digit) begin
            acc_next = acc_sat; ilen_next = g1;
          end else if (!e && c == ".") begin
            ilen_next = g1; state_next = sstok_pkg::S_FRAC;
          end else if (!e && (c == "e" || c == "E")) begin
            pend1_next = c; state_next = sstok_pkg::S_IE;
          end else begin
            em = 1'b1; em_kind = sstok_pkg::K_INT; em_ival = acc;
            state_next = sstok_pkg::S_START; push_n = 2'd1;
          end
        end
        sstok_pkg::S_FRAC: begin
          if (!e && cls.digit) begin
            ilen_next = g1;
          end else if (!e && (c == "e" || c == "E")) begin
            pend1_next = c; state_next = sstok_pkg::S_FE;
          end else begin
            em = 1'b1; em_kind = sstok_pkg::K_FLOAT;
            state_next = sstok_pkg::S_START; push_n = 2'd1;
          end
        end
        sstok_pkg::S_EXP: begin
          if (!e && cls.digit) ilen_next = g1;
          else begin
            em = 1'b1; em_kind = sstok_pkg::K_FLOAT;
            state_next = sstok_pkg::S_START; push_n = 2'd1;
          end
        end
        sstok_pkg::S_IE, sstok_pkg::S_FE: begin
          if (!e && cls.digit) begin
            ilen_next = g2; state_next = sstok_pkg::S_EXP;
          end else if (!e && (c == "+" || c == "-")) begin
            pend2_next = c;
            state_next = (state == sstok_pkg::S_FE) ? sstok_pkg::S_FES : sstok_pkg::S_IES;
          end else begin
            // exponent not taken: rescan the held letter
            em = 1'b1; state_next = sstok_pkg::S_START;
            if (state == sstok_pkg::S_FE) em_kind = sstok_pkg::K_FLOAT;
            else begin
              em_kind = sstok_pkg::K_INT; em_ival = acc;
            end
            push_n = 2'd2; psh[0] = '{ch: pend1, eos: 1'b0, off: off_m1}; psh[1] = cur;
          end
        end
        sstok_pkg::S_IES, sstok_pkg::S_FES: begin
          if (!e && cls.digit) begin
            ilen_next = g3; state_next = sstok_pkg::S_EXP;
          end else begin
            // exponent not taken: rescan letter and sign
            em = 1'b1; state_next = sstok_pkg::S_START;
            if (state == sstok_pkg::S_FES) em_kind = sstok_pkg::K_FLOAT;
            else begin
              em_kind = sstok_pkg::K_INT; em_ival = acc;
            end
            push_n = 2'd3;
            psh[0] = '{ch: pend1, eos: 1'b0, off: off_m2};
            psh[1] = '{ch: pend2, eos: 1'b0, off: off_m1};
            psh[2] = cur;
          end
        end
        sstok_pkg::S_IDENT: begin
          if (!e && (cls.alpha || cls.digit)) begin
            if (ilen < 16'd8) kwin_next = {kwin[55:0], c};
            ilen_next = g1;
          end else begin
            em = 1'b1; em_kind = sstok_pkg::kw_kind(kwin, ilen);
            state_next = sstok_pkg::S_START; push_n = 2'd1;
          end
        end
        default: state_next = state;
      endcase
    end
  end

  // re-scan buffer: pushed bytes go ahead of what is left
  always_comb begin
    if (step_char && from_pb) begin
      rest[0]  = pb[1];
      rest[1]  = pb[2];
      rest[2]  = pb[3];
      rest[3]  = pb[3];
      rest_cnt = pb_cnt - 3'd1;
    end else begin
      rest     = pb;
      rest_cnt = pb_cnt;
    end
    new_cnt = rest_cnt + 3'(push_n);
    unique case (push_n)
      2'd0: pbn = rest;
      2'd1: pbn = '{psh[0], rest[0], rest[1], rest[2]};
      2'd2: pbn = '{psh[0], psh[1], rest[0], rest[1]};
      2'd3: pbn = '{psh[0], psh[1], psh[2], rest[0]};
      default: pbn = rest;
    endcase
  end

  // token built from the step
  assign em_start_w = 48'(em_start);
  always_comb begin
    new_tok.token_kind    = em_kind;
    new_tok.start_offset  = em_start_w[31:0];
    new_tok.token_length  = em_len;
    new_tok.line_number   = 32'(em_line);
    new_tok.integer_value = em_ival;
    new_tok.bad_char      = em_bad;
    new_tok.last_of_run   = 1'b0;
  end

  // hold stage: release a token once the next one or the end of its word shows
  assign tok_new  = go && em;
  assign done_now = step_char && (new_cnt == 3'd0);
  assign out_wr   = !out_full && hold_vld && (tok_new || hold_done || done_now);
  always_comb begin
    out_tok             = hold_tok;
    out_tok.last_of_run = hold_done || (done_now && !tok_new);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sstok_pkg::S_FRESH;
      line_cnt  <= LINE_BITS'(1);
      tok_off   <= '0;
      tok_line  <= LINE_BITS'(1);
      acc       <= '0;
      kwin      <= '0;
      ilen      <= '0;
      pb_cnt    <= 3'd0;
      hold_vld  <= 1'b0;
      hold_done <= 1'b0;
    end else begin
      if (go) begin
        state     <= state_next;
        line_cnt  <= line_next;
        tok_off   <= tstart_next;
        tok_line  <= tline_next;
        acc       <= acc_next;
        kwin      <= kwin_next;
        ilen      <= ilen_next;
        if (step_char) pb_cnt <= new_cnt;
      end
      if (tok_new) begin
        hold_vld  <= 1'b1;
        hold_done <= done_now;
      end else if (out_wr) begin
        hold_vld  <= 1'b0;
        hold_done <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (go) begin
      pend1 <= pend1_next;
      pend2 <= pend2_next;
      if (step_char) pb <= pbn;
    end
    if (tok_new) hold_tok <= new_tok;
  end

endmodule

// ===== sv/sstok_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstok_outq: result queue of the tokenizer
// Four-entry queue that drives the token channel and absorbs stalls.
// ----------------------------------------------------------------------------
module sstok_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  sstok_pkg::tok_t wr_tok,
  output logic            full,
  sstok_out_if.source     tokens
);

  localparam int DEPTH = 4;

  sstok_pkg::tok_t mem [DEPTH];
  logic [1:0]      wp;
  logic [1:0]      rp;
  logic [2:0]      cnt;
  logic            pop;
  sstok_pkg::tok_t head;

  assign full         = (cnt == 3'(DEPTH));
  assign pop          = tokens.valid && tokens.ready;
  assign head         = mem[rp];
  assign tokens.valid = (cnt != 3'd0);

  assign tokens.token_kind    = head.token_kind;
  assign tokens.start_offset  = head.start_offset;
  assign tokens.token_length  = head.token_length;
  assign tokens.line_number   = head.line_number;
  assign tokens.integer_value = head.integer_value;
  assign tokens.bad_char      = head.bad_char;
  assign tokens.last_of_run   = head.last_of_run;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 2'd0;
      rp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (wr)  wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      unique case ({wr, pop})
        2'b10:   cnt <= cnt + 3'd1;
        2'b01:   cnt <= cnt - 3'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_tok;
  end

endmodule

// ===== sv/script_source_tokenizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_source_tokenizer_core: streaming tokenizer for a small script language
//
//   channel   dir  word                        handshake
//   chars     in   char_byte, end_of_source    valid / ready
//   tokens    out  token fields, last_of_run   valid / ready
//   cfg       in   source_mode                 cfg_wr_en strobe, no read-back
//
// The lexer takes one byte per cycle while the result queue is not full. A byte
// that ends a pending token is pushed to the re-scan buffer and scanned again, as
// are the bytes of a split operator pair and the letter and sign of a backed-off
// exponent; the mode sentinel takes a lexer step of its own at the start of each
// source. Reset (rst, synchronous) empties both queues and returns the
// lexer to the start of a source. A stalled token channel fills the result
// queue and then holds the lexer; the front queue keeps taking bytes until full.
// ----------------------------------------------------------------------------
module script_source_tokenizer_core #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  sstok_in_if.sink    chars,
  sstok_out_if.source tokens,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  logic                   source_mode;
  logic                   item_valid;
  logic                   item_pop;
  sstok_pkg::item_t       item;
  logic [OFFSET_BITS-1:0] item_off;
  logic                   out_full;
  logic                   out_wr;
  sstok_pkg::tok_t        out_tok;

  // mode register
  always_ff @(posedge clk) begin
    if (rst)            source_mode <= 1'b0;
    else if (cfg_wr_en) source_mode <= cfg_wr_data;
  end

  sstok_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .item_valid (item_valid),
    .item       (item),
    .item_off   (item_off),
    .item_pop   (item_pop)
  );

  sstok_lexer #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_lexer (
    .clk         (clk),
    .rst         (rst),
    .source_mode (source_mode),
    .item_valid  (item_valid),
    .item        (item),
    .item_off    (item_off),
    .item_pop    (item_pop),
    .out_full    (out_full),
    .out_wr      (out_wr),
    .out_tok     (out_tok)
  );

  sstok_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .wr     (out_wr),
    .wr_tok (out_tok),
    .full   (out_full),
    .tokens (tokens)
  );

  // result queue is never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_wr |-> !out_full)
    else $error("result queue written while full");

  // EOF always closes the run of its word
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && tokens.token_kind == sstok_pkg::K_EOF) |-> tokens.last_of_run)
    else $error("EOF token not marked last");

  // error tokens are one byte long
  a_err_len: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && tokens.token_kind == sstok_pkg::K_ERROR)
      |-> (tokens.token_length == 16'd1))
    else $error("error token with wrong length");

endmodule
